### rtl/core/bdqdm_pkg.sv
// Shared types and constants for the bounded deque with delete-minimum.
// Holds opcode, status and sequencer state encodings and the field widths.
// No dependencies.
package bdqdm_pkg;

  localparam int DEPTH_DEFAULT = 32;
  localparam int DATA_W = 32;
  localparam int OPCODE_W = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 6;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_REVERSE    = 3'd4,
    OP_DELETE_MIN = 3'd5
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_POP_DATA,
    S_SCAN,
    S_SHIFT,
    S_TAKE,
    S_OUT
  } state_t;

endpackage

### rtl/core/bounded_deque_with_delete_min_core.sv
// Bounded deque of signed values with push, pop, reverse and delete-minimum.
// A small sequencer drives one circular-address unit and a one-port-read memory.
// Depends on bdqdm_pkg.
//
// The block takes one operation per transfer and returns exactly one result per
// operation. Push, reverse, the unused opcodes and every refused request pass from
// the execute state straight to the output state; accepted pops also pass through a
// read state and a data state, and delete minimum through scan, shift and take
// states. It reads every stored entry once to find the minimum and then
// moves the entries behind it one place forward, both through the single registered
// read port of the element memory. The input is stalled while an operation is in
// progress and while its result waits for the output register; a finished result
// waits in the output register while the next input is taken.
module bounded_deque_with_delete_min_core #(
  parameter int DEPTH = bdqdm_pkg::DEPTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [bdqdm_pkg::OPCODE_W-1:0]      opcode,
  input  logic signed [bdqdm_pkg::DATA_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bdqdm_pkg::STATUS_W-1:0]      status,
  output logic signed [bdqdm_pkg::DATA_W-1:0] removed_value,
  output logic [bdqdm_pkg::COUNT_W-1:0]       count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = AW + 1;
  localparam int DW = bdqdm_pkg::DATA_W;

  bdqdm_pkg::state_t state, state_next;

  logic [bdqdm_pkg::OPCODE_W-1:0] op, op_next;
  logic signed [DW-1:0] val, val_next;
  logic [AW-1:0] first, first_next;
  logic [CW-1:0] cnt, cnt_next;
  logic reversed, reversed_next;
  logic [CW-1:0] idx, idx_next;
  logic cmp_valid, cmp_valid_next;
  logic [CW-1:0] cmp_idx, cmp_idx_next;
  logic [CW-1:0] best_idx, best_idx_next;
  logic signed [DW-1:0] best_val, best_val_next;
  logic [AW-1:0] a1, a1_next;
  logic [AW-1:0] a2, a2_next;
  logic [bdqdm_pkg::STATUS_W-1:0] res_status, res_status_next;
  logic signed [DW-1:0] res_removed, res_removed_next;
  logic out_load;

  logic signed [DW-1:0] mem [DEPTH];
  logic signed [DW-1:0] rd_data;
  logic mem_we;
  logic [AW-1:0] mem_wa;
  logic signed [DW-1:0] mem_wd;

  logic [SW-1:0] pu_off;
  logic [SW-1:0] pu_sum;
  logic [AW-1:0] pu_addr;
  logic [CW-1:0] log_off;
  logic push_dec;

  // Circular address unit: first plus an offset, wrapped once into the store.
  assign log_off = reversed ? (cnt - CW'(1) - idx) : idx;
  assign pu_sum = SW'(first) + pu_off;
  assign pu_addr = (pu_sum >= SW'(DEPTH)) ? AW'(pu_sum - SW'(DEPTH)) : AW'(pu_sum);
  assign push_dec = ((bdqdm_pkg::opcode_t'(op) == bdqdm_pkg::OP_PUSH_BACK) == reversed);

  always_comb begin
    case (state)
      bdqdm_pkg::S_EXEC: begin
        pu_off = push_dec ? SW'(DEPTH - 1) : SW'(cnt);
      end
      bdqdm_pkg::S_POP_DATA, bdqdm_pkg::S_TAKE: begin
        pu_off = SW'(1);
      end
      default: begin
        pu_off = SW'(log_off);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[pu_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdqdm_pkg::S_IDLE;
      first <= '0;
      cnt <= '0;
      reversed <= 1'b0;
      cmp_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      first <= first_next;
      cnt <= cnt_next;
      reversed <= reversed_next;
      cmp_valid <= cmp_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op <= op_next;
    val <= val_next;
    idx <= idx_next;
    cmp_idx <= cmp_idx_next;
    best_idx <= best_idx_next;
    best_val <= best_val_next;
    a1 <= a1_next;
    a2 <= a2_next;
    res_status <= res_status_next;
    res_removed <= res_removed_next;
    if (out_load) begin
      status <= res_status;
      removed_value <= res_removed;
      count <= bdqdm_pkg::COUNT_W'(cnt);
    end
  end

  always_comb begin
    state_next = state;
    op_next = op;
    val_next = val;
    first_next = first;
    cnt_next = cnt;
    reversed_next = reversed;
    idx_next = idx;
    cmp_valid_next = cmp_valid;
    cmp_idx_next = cmp_idx;
    best_idx_next = best_idx;
    best_val_next = best_val;
    a1_next = a1;
    a2_next = a2;
    res_status_next = res_status;
    res_removed_next = res_removed;
    mem_we = 1'b0;
    mem_wa = pu_addr;
    mem_wd = val;
    out_load = 1'b0;
    in_stall = (state != bdqdm_pkg::S_IDLE);

    case (state)
      bdqdm_pkg::S_IDLE: begin
        if (in_valid) begin
          op_next = opcode;
          val_next = value;
          state_next = bdqdm_pkg::S_EXEC;
        end
      end

      bdqdm_pkg::S_EXEC: begin
        res_status_next = bdqdm_pkg::STAT_DONE;
        res_removed_next = '0;
        state_next = bdqdm_pkg::S_OUT;
        case (bdqdm_pkg::opcode_t'(op))
          bdqdm_pkg::OP_PUSH_BACK, bdqdm_pkg::OP_PUSH_FRONT: begin
            if (cnt == CW'(DEPTH)) begin
              res_status_next = bdqdm_pkg::STAT_FULL;
            end else begin
              mem_we = 1'b1;
              if (push_dec) begin
                first_next = pu_addr;
              end
              cnt_next = cnt + CW'(1);
            end
          end
          bdqdm_pkg::OP_POP_BACK, bdqdm_pkg::OP_POP_FRONT: begin
            if (cnt == '0) begin
              res_status_next = bdqdm_pkg::STAT_EMPTY;
            end else begin
              idx_next = (bdqdm_pkg::opcode_t'(op) == bdqdm_pkg::OP_POP_BACK) ?
                         (cnt - CW'(1)) : '0;
              state_next = bdqdm_pkg::S_POP_RD;
            end
          end
          bdqdm_pkg::OP_REVERSE: begin
            reversed_next = !reversed;
          end
          bdqdm_pkg::OP_DELETE_MIN: begin
            if (cnt == '0) begin
              res_status_next = bdqdm_pkg::STAT_EMPTY;
            end else begin
              idx_next = '0;
              cmp_valid_next = 1'b0;
              best_idx_next = '0;
              state_next = bdqdm_pkg::S_SCAN;
            end
          end
          default: begin
          end
        endcase
      end

      bdqdm_pkg::S_POP_RD: begin
        state_next = bdqdm_pkg::S_POP_DATA;
      end

      bdqdm_pkg::S_POP_DATA: begin
        res_removed_next = rd_data;
        if ((bdqdm_pkg::opcode_t'(op) == bdqdm_pkg::OP_POP_BACK) == reversed) begin
          first_next = pu_addr;
        end
        cnt_next = cnt - CW'(1);
        state_next = bdqdm_pkg::S_OUT;
      end

      bdqdm_pkg::S_SCAN: begin
        if (cmp_valid) begin
          if ((cmp_idx == '0) || (rd_data < best_val)) begin
            best_val_next = rd_data;
            best_idx_next = cmp_idx;
          end
        end
        if (idx < cnt) begin
          cmp_valid_next = 1'b1;
          cmp_idx_next = idx;
          idx_next = idx + CW'(1);
        end else begin
          cmp_valid_next = 1'b0;
          if (!cmp_valid) begin
            idx_next = best_idx;
            state_next = bdqdm_pkg::S_SHIFT;
          end
        end
      end

      bdqdm_pkg::S_SHIFT: begin
        // Each entry read here after the minimum is written one logical place forward in the following cycle.
        a1_next = pu_addr;
        a2_next = a1;
        if (cmp_valid && (cmp_idx != best_idx)) begin
          mem_we = 1'b1;
          mem_wa = a2;
          mem_wd = rd_data;
        end
        if (idx < cnt) begin
          cmp_valid_next = 1'b1;
          cmp_idx_next = idx;
          idx_next = idx + CW'(1);
        end else begin
          cmp_valid_next = 1'b0;
          if (!cmp_valid) begin
            state_next = bdqdm_pkg::S_TAKE;
          end
        end
      end

      bdqdm_pkg::S_TAKE: begin
        res_removed_next = best_val;
        if (reversed) begin
          first_next = pu_addr;
        end
        cnt_next = cnt - CW'(1);
        state_next = bdqdm_pkg::S_OUT;
      end

      bdqdm_pkg::S_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          state_next = bdqdm_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = bdqdm_pkg::S_IDLE;
      end
    endcase
  end

endmodule
